[sv/assert_macros.svh]
// Assertion helpers for the file that checks this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/gmad_pkg.sv]
`default_nettype none
package gmad_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUMP_SPEED = 2'd1;

  localparam logic [14:0] DEADZONE_RESET = 15'd1638;
  localparam logic [14:0] DUMP_SPEED_RESET = 15'd8192;

  localparam logic [1:0] STEP_TELEOP = 2'd1;
  localparam logic [1:0] STEP_AUTONOMY = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TELEOP = 2'd1;
  localparam logic [1:0] MODE_AUTONOMY = 2'd2;

  localparam logic signed [15:0] Q15_POS_ONE = 16'sh7fff;
  localparam logic signed [15:0] Q15_NEG_ONE = 16'sh8001;
  localparam logic signed [15:0] Q15_ZERO = 16'sh0000;
  localparam logic [14:0] DIG_FULL = 15'h7fff;

  typedef struct packed {
    logic mode_key_one;
    logic mode_key_two;
    logic key_dig;
    logic key_raise;
    logic key_lower;
    logic key_dump_fwd;
    logic key_dump_rev;
    logic signed [15:0] stick_forward;
    logic signed [15:0] stick_turn;
    logic signed [15:0] trigger_right;
    logic signed [15:0] trigger_left;
    logic robot_at_rest;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_forward;
    logic signed [15:0] drive_turn;
    logic mode_changed;
    logic [1:0] mode_code;
    logic screw_valid;
    logic signed [15:0] screw_speed;
    logic actuator_valid;
    logic signed [15:0] actuator_speed;
    logic dig_valid;
    logic [14:0] dig_speed;
    logic dump_valid;
    logic signed [15:0] dump_cmd;
  } out_item_t;

  typedef struct packed {
    logic raise;
    logic lower;
    logic dig;
    logic dump_fwd;
    logic dump_rev;
  } key_edges_t;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] turn;
    logic changed;
    logic [1:0] mode_code;
    logic teleop;
    logic signed [15:0] trig_right;
    logic signed [15:0] trig_left;
    key_edges_t edges;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [1:0] mode_code_of(input logic [1:0] step);
    logic [1:0] code;
    case (step)
      STEP_TELEOP: code = MODE_TELEOP;
      STEP_AUTONOMY: code = MODE_AUTONOMY;
      default: code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

[sv/gmad_front.sv]
`default_nettype none
module gmad_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gmad_pkg::in_item_t in_data,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output gmad_pkg::entry_t       push_data
);

  logic [1:0] mode_step_r, mode_step_nxt;
  logic       prev_combo_r, prev_combo_nxt;
  logic [4:0] prev_keys_r, prev_keys_nxt;

  logic       accept;
  logic       combo;
  logic       teleop;
  logic       step_now;
  logic [4:0] keys;
  logic [4:0] rise;

  assign in_ready = push_ready;
  assign push_valid = in_valid;
  assign accept = in_valid && push_ready;

  // Key bits: 0 dig, 1 raise, 2 lower, 3 dump forward, 4 dump reverse.
  assign keys = {in_data.key_dump_rev, in_data.key_dump_fwd, in_data.key_lower,
                 in_data.key_raise, in_data.key_dig};

  always_comb begin
    combo = in_data.mode_key_one && in_data.mode_key_two;
    step_now = combo && !prev_combo_r && in_data.robot_at_rest;
    mode_step_nxt = step_now ? mode_step_r + 2'd1 : mode_step_r;
    prev_combo_nxt = combo;
    teleop = (mode_step_nxt == gmad_pkg::STEP_TELEOP);
    rise = teleop ? (keys & ~prev_keys_r) : 5'd0;
    prev_keys_nxt = teleop ? keys : prev_keys_r;

    push_data.fwd = in_data.stick_forward;
    push_data.turn = in_data.stick_turn;
    push_data.changed = step_now;
    push_data.mode_code = gmad_pkg::mode_code_of(mode_step_nxt);
    push_data.teleop = teleop;
    push_data.trig_right = in_data.trigger_right;
    push_data.trig_left = in_data.trigger_left;
    push_data.edges.dig = rise[0];
    push_data.edges.raise = rise[1];
    push_data.edges.lower = rise[2];
    push_data.edges.dump_fwd = rise[3];
    push_data.edges.dump_rev = rise[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_step_r <= 2'd0;
      prev_combo_r <= 1'b0;
      prev_keys_r <= 5'd0;
    end else if (accept) begin
      mode_step_r <= mode_step_nxt;
      prev_combo_r <= prev_combo_nxt;
      prev_keys_r <= prev_keys_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/gmad_queue.sv]
`default_nettype none
module gmad_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire gmad_pkg::entry_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output gmad_pkg::entry_t      pop_data
);

  gmad_pkg::entry_t mem [gmad_pkg::QDEPTH];

  logic [gmad_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gmad_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gmad_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push;
  logic do_pop;

  assign push_ready = (count_r != gmad_pkg::QCNT_W'(gmad_pkg::QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data = mem[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == gmad_pkg::QPTR_W'(gmad_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == gmad_pkg::QPTR_W'(gmad_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10: count_nxt = count_r + 1'b1;
      2'b01: count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/gmad_back.sv]
`default_nettype none
module gmad_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gmad_pkg::cfg_wr_t cfg_wr,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire gmad_pkg::entry_t  pop_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gmad_pkg::out_item_t    out_data
);

  logic [14:0] deadzone_r;
  logic [14:0] dump_speed_r;

  logic act_on_r, act_on_nxt;
  logic dig_on_r, dig_on_nxt;
  logic dump_on_r, dump_on_nxt;
  logic out_valid_r, out_valid_nxt;
  gmad_pkg::out_item_t out_data_r, out_data_nxt;

  logic               take;
  logic signed [15:0] dz_s;
  logic signed [15:0] ds_pos;
  logic signed [15:0] ds_neg;
  logic               lp;
  logic               rp;
  logic               act_on_mid;
  logic               dump_on_mid;
  logic signed [15:0] act_first;
  logic signed [15:0] dump_first;
  gmad_pkg::entry_t   e;

  assign take = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    e = pop_data;
    dz_s = $signed({1'b0, deadzone_r});
    ds_pos = $signed({1'b0, dump_speed_r});
    ds_neg = gmad_pkg::Q15_ZERO - ds_pos;
    lp = $signed(e.trig_left) > dz_s;
    rp = $signed(e.trig_right) > dz_s;

    out_data_nxt.drive_forward = e.fwd;
    out_data_nxt.drive_turn = e.turn;
    out_data_nxt.mode_changed = e.changed;
    out_data_nxt.mode_code = e.mode_code;
    out_data_nxt.screw_valid = e.teleop;
    if (!e.teleop || (lp && rp)) begin
      out_data_nxt.screw_speed = gmad_pkg::Q15_ZERO;
    end else if (lp) begin
      out_data_nxt.screw_speed = gmad_pkg::Q15_ZERO - $signed(e.trig_left);
    end else if (rp) begin
      out_data_nxt.screw_speed = e.trig_right;
    end else begin
      out_data_nxt.screw_speed = gmad_pkg::Q15_ZERO;
    end

    // Raise is applied before lower; the word carries the last toggle only.
    act_on_mid = act_on_r ^ e.edges.raise;
    act_first = (e.edges.raise && !act_on_r) ? gmad_pkg::Q15_NEG_ONE : gmad_pkg::Q15_ZERO;
    if (e.edges.lower) begin
      out_data_nxt.actuator_speed = act_on_mid ? gmad_pkg::Q15_ZERO : gmad_pkg::Q15_POS_ONE;
    end else begin
      out_data_nxt.actuator_speed = act_first;
    end
    out_data_nxt.actuator_valid = e.edges.raise || e.edges.lower;
    act_on_nxt = act_on_mid ^ e.edges.lower;

    out_data_nxt.dig_valid = e.edges.dig;
    out_data_nxt.dig_speed = (e.edges.dig && !dig_on_r) ? gmad_pkg::DIG_FULL : 15'd0;
    dig_on_nxt = dig_on_r ^ e.edges.dig;

    dump_on_mid = dump_on_r ^ e.edges.dump_fwd;
    dump_first = (e.edges.dump_fwd && !dump_on_r) ? ds_pos : gmad_pkg::Q15_ZERO;
    if (e.edges.dump_rev) begin
      out_data_nxt.dump_cmd = dump_on_mid ? gmad_pkg::Q15_ZERO : ds_neg;
    end else begin
      out_data_nxt.dump_cmd = dump_first;
    end
    out_data_nxt.dump_valid = e.edges.dump_fwd || e.edges.dump_rev;
    dump_on_nxt = dump_on_mid ^ e.edges.dump_rev;

    out_valid_nxt = take || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= gmad_pkg::DEADZONE_RESET;
      dump_speed_r <= gmad_pkg::DUMP_SPEED_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        gmad_pkg::CFG_TRIGGER_DEADZONE: deadzone_r <= cfg_wr.data;
        gmad_pkg::CFG_DUMP_SPEED: dump_speed_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_on_r <= 1'b0;
      dig_on_r <= 1'b0;
      dump_on_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        act_on_r <= act_on_nxt;
        dig_on_r <= dig_on_nxt;
        dump_on_r <= dump_on_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/gamepad_mode_and_actuator_decoder.sv]
// Channel   Direction  Handshake           Word
// in_       input      in_valid/in_ready   gmad_pkg::in_item_t, one gamepad report
// out_      output     out_valid/out_ready gmad_pkg::out_item_t, one result per report
// cfg_      input      cfg_valid/cfg_ready register index and 15-bit value
//
// One report per cycle sustained while out_ready is high; a result passes the queue, then the output register.
// The front stage holds the mode and key-edge state, the back stage holds the toggles.
// A two-word queue between them and the output register let either side stall alone.
// Reset is synchronous and active low; cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"
module gamepad_mode_and_actuator_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire gmad_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output gmad_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gmad_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gmad_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic             f_valid;
  logic             f_ready;
  gmad_pkg::entry_t f_data;
  logic             q_valid;
  logic             q_ready;
  gmad_pkg::entry_t q_data;
  gmad_pkg::cfg_wr_t cfg_wr;
  logic             chk_q_move;
  logic             chk_teleop;
  logic             chk_cmd_any;
  logic             chk_mode_ok;

  assign cfg_ready = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data = cfg_data;

  gmad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  gmad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  gmad_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign chk_q_move = q_valid && (!out_valid || out_ready);
  assign chk_teleop = (out_data.mode_code == gmad_pkg::MODE_TELEOP);
  assign chk_cmd_any = out_data.actuator_valid || out_data.dig_valid || out_data.dump_valid;
  assign chk_mode_ok = (out_data.screw_valid == chk_teleop) && (!chk_cmd_any || chk_teleop);

  `ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_queue_drains, chk_q_move |=> out_valid, "queued word not moved to output")
  `ASSERT_CLK(a_toggles_only_teleop, out_valid |-> chk_mode_ok, "command outside teleop")

endmodule
`default_nettype wire
